// ===== hdl/tlppc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlppc_pkg
// Shared constants for the two-level page permission checker.
// ----------------------------------------------------------------------------
package tlppc_pkg;

  // operation codes carried on func_i
  localparam logic [1:0] FuncWrite  = 2'd0;
  localparam logic [1:0] FuncCheck  = 2'd1;
  localparam logic [1:0] FuncSetUsr = 2'd2;
  localparam logic [1:0] FuncUnmap0 = 2'd3;

  // configuration port
  localparam int unsigned PaddrW     = 3;
  localparam logic        RegDirBase = 1'b0;  // register index, paddr bit 2

  // entry bits
  localparam int unsigned EntPresent = 0;
  localparam int unsigned EntUser    = 2;

  localparam int unsigned PageShift = 12;
  localparam int unsigned PageNumW  = 32 - PageShift;
  localparam int unsigned IdxW      = 10;

endpackage

// ===== hdl/two_level_page_permission_checker_core.sv =====
// ----------------------------------------------------------------------------
// two_level_page_permission_checker_core
// Page table store with range permission check, user-bit set and page-0 unmap.
// ----------------------------------------------------------------------------
// sequence: every table read is an index reduction (with estimate, subtract and
//   correct steps when TABLE_WORDS is not a power of two), a memory read and an
//   evaluate state; a write is the reduction alone, an empty or wrapping check
//   answers from idle, and a range check reads directory and table entry per page
// throughput: one transaction at a time, start is taken whenever busy is low
// reset: dir_base clears to 0; table contents are undefined until written
// the receiver cannot stall: done_o is high for exactly one cycle per result
module two_level_page_permission_checker_core #(
  parameter int unsigned TABLE_WORDS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func_i,
  input  logic [31:0]                     addr_i,
  input  logic [31:0]                     length_i,
  input  logic [31:0]                     word_i,
  // result
  output logic                            done_o,
  output logic                            allowed_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlppc_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tlppc_pkg::*;

  localparam int unsigned AW       = $clog2(TABLE_WORDS);
  localparam bit          IsPow2   = (TABLE_WORDS == (1 << AW));
  localparam int unsigned QuoW     = 32 - AW;
  localparam int unsigned ModSteps = 3;
  localparam int unsigned CntW     = 2;
  localparam logic [CntW-1:0] StepMul = 2'd3;
  localparam logic [CntW-1:0] StepSub = 2'd2;
  // floor(2^31 / TABLE_WORDS), quotient estimate is low by at most one
  localparam logic [QuoW-1:0] Recip   = QuoW'((64'd1 << 31) / 64'(TABLE_WORDS));
  localparam logic [30:0]     TabWrds = 31'(TABLE_WORDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_EVAL
  } state_e;

  typedef enum logic {
    PH_DIR,
    PH_TAB
  } phase_e;

  state_e              st_q;
  phase_e              ph_q;
  logic [1:0]          func_q;
  logic [31:0]         word_q;
  logic [31:0]         end_q;
  logic [PageNumW-1:0] page_q;
  logic [31:0]         dir_base_q;
  logic                done_q;
  logic                allowed_q;

  // index reduction unit
  logic [30:0]         rem_q;
  logic [QuoW-1:0]     quo_q;
  logic [CntW-1:0]     cnt_q;
  logic [30+QuoW:0]    mul_prod;
  logic [30:0]         quo_x_tw;
  logic                mod_done;
  logic [AW-1:0]       mod_res;

  // table memory
  logic [31:0]         mem_q [TABLE_WORDS];
  logic [AW-1:0]       slot_q;
  logic [AW-1:0]       mem_addr;
  logic [31:0]         rdata_q;
  logic                mem_we;
  logic                mem_re;
  logic [31:0]         mem_wdata;

  logic                cfg_wr;
  logic                start_acc;
  logic [32:0]         range_end;
  logic                ent_ok;
  logic                last_page;
  logic [PageNumW:0]   page_nxt;
  logic [30:0]         dir_idx;
  logic [30:0]         tab_idx;
  logic [30:0]         dir_idx_nxt;

  assign busy      = (st_q != S_IDLE);
  assign start_acc = start && !busy;
  assign done_o    = done_q;
  assign allowed_o = allowed_q;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == RegDirBase) ? dir_base_q : 32'h0;

  assign range_end = {1'b0, addr_i} + {1'b0, length_i};
  assign ent_ok    = rdata_q[EntPresent] && rdata_q[EntUser];
  assign page_nxt  = {1'b0, page_q} + {{PageNumW{1'b0}}, 1'b1};
  assign last_page = {page_nxt, {PageShift{1'b0}}} >= {1'b0, end_q};

  // directory index: (dir_base >> 2) + page[19:10]; table index needs no add
  assign dir_idx     = {1'b0, dir_base_q[31:2]} + {21'h0, page_q[PageNumW-1:IdxW]};
  assign dir_idx_nxt = {1'b0, dir_base_q[31:2]}
                     + {21'h0, page_nxt[PageNumW-1:IdxW]};
  assign tab_idx     = {1'b0, rdata_q[31:PageShift], page_q[IdxW-1:0]};

  // reciprocal reduction: estimate quotient, subtract, one correction step
  assign mul_prod = {{QuoW{1'b0}}, rem_q} * {31'h0, Recip};
  assign quo_x_tw = {{(31-QuoW){1'b0}}, quo_q} * TabWrds;

  assign mod_done = IsPow2 || (cnt_q == '0);
  assign mod_res  = rem_q[AW-1:0];
  // a table-word write goes out in the reduction cycle itself
  assign mem_addr = (st_q == S_MOD) ? mod_res : slot_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rdata_q;
    mem_re    = (st_q == S_READ);
    case (st_q)
      S_MOD: begin
        if (mod_done && func_q == FuncWrite) begin
          mem_we    = 1'b1;
          mem_wdata = word_q;
        end
      end
      S_EVAL: begin
        if (func_q == FuncSetUsr) begin
          mem_we    = (ph_q == PH_TAB) || rdata_q[EntPresent];
          mem_wdata = rdata_q | (32'h1 << EntUser);
        end else if (func_q == FuncUnmap0 && ph_q == PH_TAB) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q & ~(32'h1 << EntPresent);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      ph_q       <= PH_DIR;
      done_q     <= 1'b0;
      allowed_q  <= 1'b0;
      dir_base_q <= 32'h0;
      func_q     <= FuncWrite;
      word_q     <= 32'h0;
      end_q      <= 32'h0;
      page_q     <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      cnt_q      <= '0;
      slot_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_wr && paddr[2] == RegDirBase) begin
        dir_base_q <= pwdata;
      end
      case (st_q)
        S_IDLE: begin
          if (start_acc) begin
            func_q <= func_i;
            word_q <= word_i;
            end_q  <= range_end[31:0];
            ph_q   <= PH_DIR;
            cnt_q  <= CntW'(ModSteps);
            case (func_i)
              FuncWrite: begin
                rem_q <= {1'b0, addr_i[31:2]};
                st_q  <= S_MOD;
              end
              FuncCheck: begin
                page_q <= addr_i[31:PageShift];
                rem_q  <= {1'b0, dir_base_q[31:2]} + {21'h0, addr_i[31:22]};
                if (length_i == 32'h0 || range_end[32]) begin
                  // empty range passes, wrapping range fails
                  done_q    <= 1'b1;
                  allowed_q <= (length_i == 32'h0);
                end else begin
                  st_q <= S_MOD;
                end
              end
              FuncSetUsr: begin
                page_q <= addr_i[31:PageShift];
                rem_q  <= {1'b0, dir_base_q[31:2]} + {21'h0, addr_i[31:22]};
                st_q   <= S_MOD;
              end
              default: begin
                page_q <= '0;
                rem_q  <= {1'b0, dir_base_q[31:2]};
                st_q   <= S_MOD;
              end
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            slot_q <= mod_res;
            if (func_q == FuncWrite) begin
              done_q    <= 1'b1;
              allowed_q <= 1'b1;
              st_q      <= S_IDLE;
            end else begin
              st_q <= S_READ;
            end
          end else begin
            case (cnt_q)
              StepMul: begin
                quo_q <= mul_prod[31 +: QuoW];
              end
              StepSub: begin
                rem_q <= rem_q - quo_x_tw;
              end
              default: begin
                if (rem_q >= TabWrds) begin
                  rem_q <= rem_q - TabWrds;
                end
              end
            endcase
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        S_READ: begin
          st_q <= S_EVAL;
        end
        S_EVAL: begin
          cnt_q <= CntW'(ModSteps);
          if (func_q == FuncCheck) begin
            if (!ent_ok) begin
              done_q    <= 1'b1;
              allowed_q <= 1'b0;
              st_q      <= S_IDLE;
            end else if (ph_q == PH_DIR) begin
              rem_q <= tab_idx;
              ph_q  <= PH_TAB;
              st_q  <= S_MOD;
            end else if (last_page) begin
              done_q    <= 1'b1;
              allowed_q <= 1'b1;
              st_q      <= S_IDLE;
            end else begin
              page_q <= page_nxt[PageNumW-1:0];
              rem_q  <= dir_idx_nxt;
              ph_q   <= PH_DIR;
              st_q   <= S_MOD;
            end
          end else if (ph_q == PH_DIR && rdata_q[EntPresent]) begin
            rem_q <= tab_idx;
            ph_q  <= PH_TAB;
            st_q  <= S_MOD;
          end else begin
            done_q    <= 1'b1;
            allowed_q <= 1'b1;
            st_q      <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
      if (st_q == S_IDLE && !start_acc) begin
        rem_q <= dir_idx;
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_level_page_permission_checker_core. Page tables
// are built through table-word writes, then range checks, user-bit sets and
// page-0 unmaps run against them. Every verdict is compared with an in-bench
// table walk that keeps its own copy of the table store and dir_base.
// ----------------------------------------------------------------------------
module tb;
  import tlppc_pkg::*;

  localparam int unsigned TableWords = 65536;
  localparam int unsigned NumBlocks  = TableWords / 1024;
  localparam int unsigned WalkCap    = 24;
  localparam int unsigned ItemGoal   = 950;
  localparam logic [31:0] FrameMask  = 32'hFFFF_F000;
  localparam logic [31:0] IdxMask    = 32'h0000_03FF;
  localparam logic [32:0] PageBytes  = 33'd4096;
  localparam logic [31:0] FlagP      = 32'd1 << EntPresent;
  localparam logic [31:0] FlagU      = 32'd1 << EntUser;
  localparam logic [PaddrW-1:0] DirBaseAddr = {RegDirBase, 2'b00};

  typedef struct {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [31:0] len;
    bit          verdict;
  } verdict_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        func_i;
  logic [31:0]       addr_i;
  logic [31:0]       length_i;
  logic [31:0]       word_i;
  logic              done_o;
  logic              allowed_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // bench copy of the table store and the directory base
  bit [31:0]   tbl_mem [TableWords];
  bit          tbl_set [TableWords];
  logic [31:0] dir_base_m;

  verdict_t    verdict_q[$];
  int unsigned items_sent;
  int unsigned fail_cnt;
  int unsigned burst_left;
  logic [31:0] hot_va [16];

  two_level_page_permission_checker_core #(
    .TABLE_WORDS(TableWords)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .func_i   (func_i),
    .addr_i   (addr_i),
    .length_i (length_i),
    .word_i   (word_i),
    .done_o   (done_o),
    .allowed_o(allowed_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic void note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  // ---------------- table walk ----------------

  function automatic int unsigned word_slot(logic [31:0] base_words, logic [31:0] offset);
    logic [63:0] sum;
    sum = {32'd0, base_words} + {32'd0, offset};
    return sum % TableWords;
  endfunction

  function automatic int unsigned dir_slot(logic [31:0] va);
    return word_slot(dir_base_m >> 2, va >> 22);
  endfunction

  function automatic int unsigned tab_slot(logic [31:0] pde, logic [31:0] va);
    return word_slot((pde & FrameMask) >> 2, (va >> PageShift) & IdxMask);
  endfunction

  function automatic bit entry_ok(logic [31:0] e);
    return e[EntPresent] && e[EntUser];
  endfunction

  function automatic bit page_ok(logic [31:0] va);
    logic [31:0] pde;
    pde = tbl_mem[dir_slot(va)];
    if (!entry_ok(pde)) return 1'b0;
    return entry_ok(tbl_mem[tab_slot(pde, va)]);
  endfunction

  function automatic bit range_ok(logic [31:0] a, logic [31:0] l);
    logic [32:0] lim;
    logic [32:0] pg;
    if (l == 32'd0) return 1'b1;
    lim = {1'b0, a} + {1'b0, l};
    if (lim[32]) return 1'b0;
    // stops after the last page, never wraps to page zero
    for (pg = {1'b0, a & FrameMask}; pg < lim; pg = pg + PageBytes)
      if (!page_ok(pg[31:0])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit apply_cmd(logic [1:0] f, logic [31:0] a, logic [31:0] l,
                                   logic [31:0] w);
    int unsigned ds;
    int unsigned ts;
    logic [31:0] pde;
    bit          ok;
    ok = 1'b1;
    case (f)
      FuncWrite: begin
        ds = word_slot(a >> 2, 32'd0);
        tbl_mem[ds] = w;
        tbl_set[ds] = 1'b1;
      end
      FuncCheck: begin
        ok = range_ok(a, l);
      end
      FuncSetUsr: begin
        ds  = dir_slot(a);
        pde = tbl_mem[ds];
        if (pde[EntPresent]) begin
          pde         = pde | FlagU;
          tbl_mem[ds] = pde;
          ts          = tab_slot(pde, a);
          tbl_mem[ts] = tbl_mem[ts] | FlagU;
        end
      end
      FuncUnmap0: begin
        pde = tbl_mem[dir_slot(32'd0)];
        if (pde[EntPresent]) begin
          ts          = tab_slot(pde, 32'd0);
          tbl_mem[ts] = tbl_mem[ts] & ~FlagP;
        end
      end
    endcase
    return ok;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [31:0] rand_entry();
    logic [31:0] v;
    v = $urandom();
    // keep half the tables in a few blocks so walks revisit written entries
    if ($urandom_range(0, 1) == 0) v[PageShift +: 6] = 6'($urandom_range(0, 3));
    if ($urandom_range(0, 3) != 0) v = v | FlagP | FlagU;
    return v;
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 9) < 7)
      return hot_va[$urandom_range(0, 15)] + 32'($urandom_range(0, 32'h2FFF));
    return $urandom();
  endfunction

  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    case ($urandom_range(0, 3))
      0: gap = 0;
      1, 2: gap = $urandom_range(1, 4);
      default: gap = $urandom_range(5, 30);
    endcase
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic send_cmd(input logic [1:0] f, input logic [31:0] a, input logic [31:0] l,
                          input logic [31:0] w);
    verdict_t e;
    @(negedge clk_i);
    start    <= 1'b1;
    func_i   <= f;
    addr_i   <= a;
    length_i <= l;
    word_i   <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    e.func    = f;
    e.addr    = a;
    e.len     = l;
    e.verdict = apply_cmd(f, a, l, w);
    verdict_q.push_back(e);
    items_sent++;
    pace();
  endtask

  task automatic put_word(input int unsigned slot, input logic [31:0] value);
    logic [31:0] a;
    a = ($urandom() & ~(32'(TableWords) * 4 - 1)) | (32'(slot) << 2) |
        32'($urandom_range(0, 3));
    send_cmd(FuncWrite, a, $urandom(), value);
  endtask

  // a table word is always written before the block can read it
  task automatic fill(input int unsigned slot);
    if (!tbl_set[slot]) put_word(slot, rand_entry());
  endtask

  task automatic check_range(input logic [31:0] a, input logic [31:0] l);
    logic [32:0] lim;
    logic [32:0] pg;
    logic [31:0] pte;
    int unsigned ds;
    int unsigned ts;
    int unsigned walked;
    lim    = {1'b0, a} + {1'b0, l};
    walked = 0;
    if (l != 32'd0 && !lim[32]) begin
      for (pg = {1'b0, a & FrameMask}; pg < lim; pg = pg + PageBytes) begin
        ds = dir_slot(pg[31:0]);
        fill(ds);
        if (!entry_ok(tbl_mem[ds])) break;
        ts = tab_slot(tbl_mem[ds], pg[31:0]);
        fill(ts);
        pte = tbl_mem[ts];
        // bound the walk length on long ranges
        if (entry_ok(pte) && walked >= WalkCap) put_word(ts, pte & ~FlagP);
        if (!entry_ok(tbl_mem[ts])) break;
        walked++;
      end
    end
    send_cmd(FuncCheck, a, l, $urandom());
  endtask

  task automatic set_user_page(input logic [31:0] a);
    int unsigned ds;
    ds = dir_slot(a);
    fill(ds);
    if (tbl_mem[ds][EntPresent]) fill(tab_slot(tbl_mem[ds], a));
    send_cmd(FuncSetUsr, a, $urandom(), $urandom());
  endtask

  task automatic unmap_zero_page();
    int unsigned ds;
    ds = dir_slot(32'd0);
    fill(ds);
    if (tbl_mem[ds][EntPresent]) fill(tab_slot(tbl_mem[ds], 32'd0));
    send_cmd(FuncUnmap0, $urandom(), $urandom(), $urandom());
  endtask

  // table placed in a block other than the directory's
  task automatic map_page(input logic [31:0] va, input logic [31:0] pde_flags,
                          input logic [31:0] pte_flags);
    int unsigned ds;
    int unsigned blk;
    logic [31:0] pde;
    ds  = dir_slot(va);
    blk = ((ds >> 10) + 1 + $urandom_range(0, NumBlocks - 2)) % NumBlocks;
    pde = $urandom() & FrameMask;
    pde[PageShift +: 6] = blk[5:0];
    pde = pde | ($urandom() & 32'hFFF & ~(FlagP | FlagU)) | pde_flags;
    put_word(ds, pde);
    put_word(tab_slot(pde, va), ($urandom() & ~(FlagP | FlagU)) | pte_flags);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (verdict_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------- configuration port ----------------

  task automatic apb_access(input logic wr, input logic [PaddrW-1:0] a,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_dir_base(input logic [31:0] v);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, DirBaseAddr, v, rd);
    dir_base_m = v;
    apb_access(1'b0, DirBaseAddr, 32'd0, rd);
    if (rd !== v) note_fail($sformatf("dir_base readback: expected %h actual %h", v, rd));
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk_i) begin : result_mon
    verdict_t e;
    if (rst_ni && done_o === 1'b1) begin
      if (verdict_q.size() == 0) begin
        note_fail($sformatf("result with no transaction pending: allowed %b", allowed_o));
      end else begin
        e = verdict_q.pop_front();
        if (allowed_o !== e.verdict)
          note_fail($sformatf("allowed mismatch: func %0d addr %h length %h expected %0b actual %b",
                              e.func, e.addr, e.len, e.verdict, allowed_o));
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_range_edges();
    check_range(32'h1234_5678, 32'd0);
    check_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    check_range(32'hFFFF_F000, 32'h0000_1000);
    map_page(32'hFFFF_F000, FlagP | FlagU, FlagP | FlagU);
    check_range(32'hFFFF_F000, 32'h0000_0FFF);
    check_range(32'hFFFF_FFFF, 32'd0);
    // range straddling two directory entries
    map_page(32'h003F_F000, FlagP | FlagU, FlagP | FlagU);
    map_page(32'h0040_0000, FlagP | FlagU, FlagP | FlagU);
    check_range(32'h003F_F800, 32'h0000_1000);
    check_range(32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_set_user();
    map_page(32'h0804_8000, FlagP, FlagP);
    check_range(32'h0804_8000, 32'd1);
    set_user_page(32'h0804_8123);
    check_range(32'h0804_8000, 32'h0000_1000);
    // absent directory entry stays untouched
    map_page(32'h4000_0000, 32'd0, FlagP | FlagU);
    set_user_page(32'h4000_0000);
    check_range(32'h4000_0000, 32'd1);
  endtask

  task automatic test_unmap_zero();
    map_page(32'd0, FlagP | FlagU, FlagP | FlagU);
    check_range(32'd0, 32'd1);
    unmap_zero_page();
    check_range(32'd0, 32'h0000_1000);
    map_page(32'd0, FlagU, FlagP | FlagU);
    unmap_zero_page();
    check_range(32'd0, 32'd1);
  endtask

  task automatic test_write_extremes();
    send_cmd(FuncWrite, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(FuncWrite, 32'h0000_0004, 32'd0, 32'd0);
    check_range(32'hFFFF_F000, 32'h0000_0FFF);
  endtask

  task automatic test_random(input int unsigned goal);
    logic [31:0] a;
    logic [31:0] l;
    int unsigned r;
    int unsigned ds;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) hot_va[$urandom_range(0, 15)] = $urandom() & FrameMask;
      if (r < 45) begin
        a = pick_addr();
        case ($urandom_range(0, 9))
          0: l = 32'd0;
          1: l = $urandom();
          2: l = ~a + 32'($urandom_range(0, 1));  // end at the top or just past it
          3, 4: l = $urandom_range(1, 32'h0001_0000);
          default: l = $urandom_range(1, 32'h3000);
        endcase
        check_range(a, l);
      end else if (r < 60) begin
        set_user_page(pick_addr());
      end else if (r < 66) begin
        unmap_zero_page();
      end else if (r < 82) begin
        a  = pick_addr();
        ds = dir_slot(a);
        if ($urandom_range(0, 1) == 0 && tbl_set[ds] && tbl_mem[ds][EntPresent])
          put_word(tab_slot(tbl_mem[ds], a), rand_entry());
        else
          put_word(ds, rand_entry());
      end else begin
        send_cmd(FuncWrite, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    func_i     = FuncWrite;
    addr_i     = 32'd0;
    length_i   = 32'd0;
    word_i     = 32'd0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = 32'd0;
    dir_base_m = 32'd0;
    items_sent = 0;
    fail_cnt   = 0;
    burst_left = 0;
    hot_va[0]  = 32'h0000_0000;
    hot_va[1]  = 32'hFFFF_E000;
    hot_va[2]  = 32'h003F_F000;
    hot_va[3]  = 32'h0804_8000;
    for (int i = 4; i < 16; i++) hot_va[i] = $urandom() & FrameMask;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_range_edges();
    test_set_user();
    test_unmap_zero();
    test_write_extremes();

    set_dir_base(32'hFFFF_F000);
    test_range_edges();
    test_random(350);
    set_dir_base($urandom() & FrameMask);
    test_random(550);
    drain();
    test_random(700);
    set_dir_base(32'd0);
    test_random(ItemGoal);

    @(negedge clk_i);
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
